// File: design/mcg_pkg.sv
package mcg_pkg;

  localparam int GRID_CELLS = 42;
  localparam int GRID_COLS  = 7;
  localparam int CELL_W     = 6;
  localparam int YEAR_W     = 16;
  localparam int OYEAR_W    = 17;
  localparam int CYCLE_OFFSET = 400;
  localparam int DIV100_MUL = 83887;
  localparam int DIV100_SH  = 23;
  localparam int DIV7_MUL   = 37449;
  localparam int DIV7_SH    = 18;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [CELL_W-1:0] LAST_CELL_IDX = CELL_W'(GRID_CELLS - 1);
  localparam logic [2:0] LAST_COL = 3'(GRID_COLS - 1);

  // 3(m+1) minus the march correction (4m+23)/10
  function automatic logic [5:0] month_offset(input logic [3:0] m);
    logic [5:0] r;
    unique case (m)
      4'd1:    r = 6'd6;
      4'd2:    r = 6'd9;
      4'd3:    r = 6'd9;
      4'd4:    r = 6'd12;
      4'd5:    r = 6'd14;
      4'd6:    r = 6'd17;
      4'd7:    r = 6'd19;
      4'd8:    r = 6'd22;
      4'd9:    r = 6'd25;
      4'd10:   r = 6'd27;
      4'd11:   r = 6'd30;
      4'd12:   r = 6'd32;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] cell_day(input logic [CELL_W-1:0] k, input logic [2:0] fw,
                                          input logic [4:0] len, input logic bad);
    logic [CELL_W-1:0] d;
    logic [4:0] r;
    d = k - CELL_W'(fw) + CELL_W'(1);
    r = 5'd0;
    if (!bad && (k >= CELL_W'(fw)) && (d <= CELL_W'(len))) begin
      r = d[4:0];
    end
    return r;
  endfunction

endpackage

// File: design/month_calendar_grid.sv
// month calendar grid generator
// input channel: in_valid / in_stall with month (4 bits) and year (16 bits);
//   a beat is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with one grid cell per beat:
//   day_number, grid_row, grid_column, first_weekday, month_length,
//   bad_month and last_cell
// every input beat yields 42 output beats in row-major order, Sunday first;
//   last_cell marks the 42nd
// the first cell reaches the output registers once the month has passed stages
//   a to e; throughput: one cell per cycle while out_stall is low; the output
//   cell counter sets this rate, while the five-stage weekday/leap pipeline
//   ahead of it holds up to five more months and keeps taking input beats
// a month outside 1..12 still gives 42 cells, all empty, with bad_month set
// when out_stall is high the current cell holds and the pipeline fills up,
//   after which in_stall rises
// rst is synchronous and active high; it empties the pipeline and drops
//   out_valid
module month_calendar_grid
  import mcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  month,
  input  logic [15:0] year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  day_number,
  output logic [2:0]  grid_row,
  output logic [2:0]  grid_column,
  output logic [2:0]  first_weekday,
  output logic [4:0]  month_length,
  output logic        bad_month,
  output logic        last_cell
);

  // stage a: input
  logic               va;
  logic [3:0]         a_month;
  logic [YEAR_W-1:0]  a_year;
  // stage b: offset years
  logic               vb;
  logic [3:0]         b_month;
  logic [OYEAR_W-1:0] b_yr;
  logic [OYEAR_W-1:0] b_y;
  // stage c: centuries
  logic               vc;
  logic [3:0]         c_month;
  logic [OYEAR_W-1:0] c_yr;
  logic [OYEAR_W-1:0] c_y;
  logic [9:0]         c_qy;
  logic [9:0]         c_qyr;
  // stage d: weekday sum and length
  logic               vd;
  logic [OYEAR_W-1:0] d_w;
  logic [4:0]         d_len;
  logic               d_bad;
  // stage e: weekday
  logic               ve;
  logic [2:0]         e_fw;
  logic [4:0]         e_len;
  logic               e_bad;

  logic [CELL_W-1:0]  cnt;

  logic load_out, step_out;
  logic rdy_e, rdy_d, rdy_c, rdy_b, rdy_a;

  assign load_out = ve && (!out_valid || (!out_stall && last_cell));
  assign step_out = out_valid && !out_stall && !last_cell;
  assign rdy_e    = !ve || load_out;
  assign rdy_d    = !vd || rdy_e;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;

  logic [OYEAR_W-1:0] yr_comb;
  assign yr_comb = OYEAR_W'(a_year) + OYEAR_W'(CYCLE_OFFSET);

  logic [33:0] prod_y, prod_yr;
  assign prod_y  = 34'(b_y) * 34'(DIV100_MUL);
  assign prod_yr = 34'(b_yr) * 34'(DIV100_MUL);

  logic [OYEAR_W-1:0] rem_yr;
  logic [6:0]         rem7;
  logic               leap;
  logic               bad_comb;
  logic [11:0]        cent_term;
  logic [OYEAR_W-1:0] w_comb;
  assign rem_yr    = c_yr - OYEAR_W'(c_qyr) * OYEAR_W'(100);
  assign rem7      = rem_yr[6:0];
  assign leap      = ((c_yr[1:0] == 2'd0) && (rem7 != 7'd0)) ||
                     ((rem7 == 7'd0) && (c_qyr[1:0] == 2'd0));
  assign bad_comb  = (c_month < MONTH_JAN) || (c_month > MONTH_DEC);
  assign cent_term = (12'(c_qy) + 12'd1) * 12'd3;
  assign w_comb    = c_yr + OYEAR_W'(1) + OYEAR_W'(month_offset(c_month))
                   + OYEAR_W'(c_y >> 2) - OYEAR_W'(cent_term >> 2);

  logic [32:0]        prod_w;
  logic [OYEAR_W-1:0] r_full;
  logic [3:0]         r_mod;
  logic [2:0]         fw_comb;
  assign prod_w  = 33'(d_w) * 33'(DIV7_MUL);
  assign r_full  = d_w - OYEAR_W'(prod_w[32:DIV7_SH]) * OYEAR_W'(GRID_COLS);
  assign r_mod   = r_full[3:0];
  assign fw_comb = (r_mod >= 4'(GRID_COLS)) ? 3'(r_mod - 4'(GRID_COLS)) : r_mod[2:0];

  logic [CELL_W-1:0] cnt_next;
  assign cnt_next = cnt + CELL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
      if (rdy_e) ve <= vd;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall && last_cell) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_month <= month;
      a_year  <= year;
    end
    if (rdy_b) begin
      b_month <= a_month;
      b_yr    <= yr_comb;
      b_y     <= (a_month < MONTH_MAR) ? yr_comb - OYEAR_W'(1) : yr_comb;
    end
    if (rdy_c) begin
      c_month <= b_month;
      c_yr    <= b_yr;
      c_y     <= b_y;
      c_qy    <= prod_y[DIV100_SH+9:DIV100_SH];
      c_qyr   <= prod_yr[DIV100_SH+9:DIV100_SH];
    end
    if (rdy_d) begin
      d_w   <= w_comb;
      d_bad <= bad_comb;
      d_len <= bad_comb ? 5'd0 : month_days(c_month, leap);
    end
    if (rdy_e) begin
      e_fw  <= d_bad ? 3'd0 : fw_comb;
      e_len <= d_len;
      e_bad <= d_bad;
    end
    if (load_out) begin
      cnt           <= '0;
      grid_row      <= 3'd0;
      grid_column   <= 3'd0;
      last_cell     <= 1'b0;
      first_weekday <= e_fw;
      month_length  <= e_len;
      bad_month     <= e_bad;
      day_number    <= cell_day('0, e_fw, e_len, e_bad);
    end else if (step_out) begin
      cnt       <= cnt_next;
      last_cell <= (cnt_next == LAST_CELL_IDX);
      if (grid_column == LAST_COL) begin
        grid_column <= 3'd0;
        grid_row    <= grid_row + 3'd1;
      end else begin
        grid_column <= grid_column + 3'd1;
      end
      day_number <= cell_day(cnt_next, first_weekday, month_length, bad_month);
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mcg_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [4:0] day;
    logic [2:0] row;
    logic [2:0] col;
    logic [2:0] fw;
    logic [4:0] len;
    logic       bad;
    logic       last;
  } grid_cell_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  month;
  logic [15:0] year;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  day_number;
  logic [2:0]  grid_row;
  logic [2:0]  grid_column;
  logic [2:0]  first_weekday;
  logic [4:0]  month_length;
  logic        bad_month;
  logic        last_cell;

  grid_cell_t  cells_due[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_mode;

  month_calendar_grid DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .month        (month),
    .year         (year),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .day_number   (day_number),
    .grid_row     (grid_row),
    .grid_column  (grid_column),
    .first_weekday(first_weekday),
    .month_length (month_length),
    .bad_month    (bad_month),
    .last_cell    (last_cell)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // weekday of the 1st and month length, then the 42 grid cells
  task automatic predict_grid(input logic [3:0] m, input logic [15:0] y);
    int unsigned mi, yi, oy, yd, w, fw, len, d;
    bit          bad;
    grid_cell_t  c;
    mi = m;
    yi = y;
    bad = (mi < 1) || (mi > 12);
    fw = 0;
    len = 0;
    if (!bad) begin
      oy = yi + 400;
      yd = (mi < 3) ? oy - 1 : oy;
      w = oy + 1 + 3 * (mi + 1);
      if (mi >= 3) begin
        w -= (4 * mi + 23) / 10;
      end
      w += yd / 4;
      w -= (3 * (yd / 100 + 1)) / 4;
      fw = w % 7;
      if (mi == 4 || mi == 6 || mi == 9 || mi == 11) begin
        len = 30;
      end else if (mi == 2) begin
        len = (((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0)) ? 29 : 28;
      end else begin
        len = 31;
      end
    end
    for (int k = 0; k < GRID_CELLS; k++) begin
      c.day = '0;
      if (!bad && k >= fw) begin
        d = k - fw + 1;
        if (d <= len) begin
          c.day = d[4:0];
        end
      end
      c.row = 3'(k / GRID_COLS);
      c.col = 3'(k % GRID_COLS);
      c.fw = fw[2:0];
      c.len = len[4:0];
      c.bad = bad;
      c.last = (k == GRID_CELLS - 1);
      cells_due.push_back(c);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    grid_cell_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_grid(month, year);
      end
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          $error("unexpected output beat");
          mismatch_count++;
        end else begin
          want = cells_due.pop_front();
          check_field("day_number", want.day, day_number);
          check_field("grid_row", want.row, grid_row);
          check_field("grid_column", want.col, grid_column);
          check_field("first_weekday", want.fw, first_weekday);
          check_field("month_length", want.len, month_length);
          check_field("bad_month", want.bad, bad_month);
          check_field("last_cell", want.last, last_cell);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // output backpressure
  initial begin
    int unsigned run, hold;
    out_stall = 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_month(input logic [3:0] m, input logic [15:0] y);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    month <= m;
    year <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic test_every_month();
    idle_mode = 1'b0;
    for (int m = 0; m < 16; m++) begin
      send_month(4'(m), 16'(1990 + 3 * m));
    end
  endtask

  task automatic test_year_extremes();
    idle_mode = 1'b1;
    send_month(MONTH_JAN, 16'd0);
    send_month(MONTH_JAN, 16'd1);
    send_month(MONTH_DEC, 16'd65535);
    send_month(MONTH_FEB, 16'd65535);
    send_month(4'd15, 16'd65535);
  endtask

  task automatic test_leap_rules();
    idle_mode = 1'b1;
    send_month(MONTH_FEB, 16'd0);
    send_month(MONTH_FEB, 16'd1900);
    send_month(MONTH_FEB, 16'd2000);
    send_month(MONTH_FEB, 16'd2024);
    send_month(MONTH_FEB, 16'd2023);
    send_month(MONTH_MAR, 16'd2000);
  endtask

  task automatic test_random_months();
    logic [3:0]  m;
    logic [15:0] y;
    int unsigned r;
    for (int i = 0; i < 150; i++) begin
      if (i % 45 == 0) begin
        idle_mode = (i != 90);
      end
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 3);
        m = (r == 0) ? 4'd0 : 4'(12 + r);
      end else begin
        m = 4'($urandom_range(1, 12));
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        y = 16'($urandom_range(0, 65535));
      end else if (r < 6) begin
        y = 16'($urandom_range(1, 2100));
      end else if (r < 8) begin
        y = 16'($urandom_range(0, 655) * 100);
      end else if (r == 8) begin
        y = 16'($urandom_range(0, 16383) * 4);
      end else begin
        r = $urandom_range(0, 3);
        y = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'd65534 : 16'd65535;
      end
      send_month(m, y);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    month = '0;
    year = '0;
    idle_mode = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_month();
    test_year_extremes();
    test_leap_rules();
    test_random_months();
    drain();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mcg_pkg.sv
design/month_calendar_grid.sv
bench/testbench.sv
